// ===== sv/assert_macros.svh =====
// Assertion macros used by cc20_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== sv/cc20_pkg.sv =====
package cc20_pkg;

    localparam int ROUND_COUNT_DEF = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd6;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       step;
        logic [1:0] step_idx;
        logic       diag;
        logic       final_add;
        logic       emit_in;
        logic       emit_held;
    } t_cmd;

    typedef struct packed {
        logic pos_zero;
    } t_status;

    // One quarter-round step: rotation by 16, 12, 8 or 7.
    function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] s);
        logic [31:0] r;
        case (s)
            2'd0: r = {v[15:0], v[31:16]};
            2'd1: r = {v[19:0], v[31:20]};
            2'd2: r = {v[23:0], v[31:24]};
            default: r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

endpackage

// ===== sv/cc20_dp.sv =====
module cc20_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cc20_pkg::t_cmd                      i_cmd,
    output cc20_pkg::t_status                   o_status,
    input  logic                                i_restart,
    input  logic [7:0]                          i_data,
    input  logic                                i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [7:0]                          o_data
);

    logic [63:0] r_key [4];
    logic [31:0] r_ctr_start;
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [31:0] r_counter;
    logic [5:0]  r_pos;
    logic [31:0] r_w [16];
    logic [7:0]  r_data;
    logic [7:0]  r_out_data;

    logic [31:0] init_w [16];
    logic [31:0] n_w    [16];
    logic [31:0] n_fin  [16];
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    always_comb begin
        init_w[0]  = cc20_pkg::SIGMA_0;
        init_w[1]  = cc20_pkg::SIGMA_1;
        init_w[2]  = cc20_pkg::SIGMA_2;
        init_w[3]  = cc20_pkg::SIGMA_3;
        for (int k = 0; k < 4; k++) begin
            init_w[4 + 2 * k] = r_key[k][31:0];
            init_w[5 + 2 * k] = r_key[k][63:32];
        end
        init_w[12] = r_counter;
        init_w[13] = r_nonce_lo[31:0];
        init_w[14] = r_nonce_lo[63:32];
        init_w[15] = r_nonce_hi;
    end

    // Four quarter rounds side by side, one add-xor-rotate step per cycle.
    always_comb begin
        logic [31:0] va, vb, vc, vd, sum;
        n_w = r_w;
        for (int l = 0; l < 4; l++) begin
            va = r_w[l];
            vb = i_cmd.diag ? r_w[4 + ((l + 1) & 3)]  : r_w[4 + l];
            vc = i_cmd.diag ? r_w[8 + ((l + 2) & 3)]  : r_w[8 + l];
            vd = i_cmd.diag ? r_w[12 + ((l + 3) & 3)] : r_w[12 + l];
            if (!i_cmd.step_idx[0]) begin
                sum = va + vb;
                n_w[l] = sum;
                if (i_cmd.diag) begin
                    n_w[12 + ((l + 3) & 3)] = cc20_pkg::rotl_step(vd ^ sum, i_cmd.step_idx);
                end else begin
                    n_w[12 + l] = cc20_pkg::rotl_step(vd ^ sum, i_cmd.step_idx);
                end
            end else begin
                sum = vc + vd;
                if (i_cmd.diag) begin
                    n_w[8 + ((l + 2) & 3)] = sum;
                    n_w[4 + ((l + 1) & 3)] = cc20_pkg::rotl_step(vb ^ sum, i_cmd.step_idx);
                end else begin
                    n_w[8 + l] = sum;
                    n_w[4 + l] = cc20_pkg::rotl_step(vb ^ sum, i_cmd.step_idx);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_fin[i] = r_w[i] + init_w[i];
        end
    end

    assign ks_word = r_w[r_pos[5:2]];
    assign ks_byte = 8'(ks_word >> {r_pos[1:0], 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
            r_ctr_start <= '0;
            r_nonce_lo  <= '0;
            r_nonce_hi  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cc20_pkg::CFG_KEY_0:     r_key[0]    <= i_cfg_data;
                cc20_pkg::CFG_KEY_1:     r_key[1]    <= i_cfg_data;
                cc20_pkg::CFG_KEY_2:     r_key[2]    <= i_cfg_data;
                cc20_pkg::CFG_KEY_3:     r_key[3]    <= i_cfg_data;
                cc20_pkg::CFG_CTR_START: r_ctr_start <= i_cfg_data[31:0];
                cc20_pkg::CFG_NONCE_LO:  r_nonce_lo  <= i_cfg_data;
                cc20_pkg::CFG_NONCE_HI:  r_nonce_hi  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cmd.capture && i_restart) begin
                r_counter <= r_ctr_start;
                r_pos     <= '0;
            end else if (i_cmd.final_add) begin
                r_counter <= r_counter + 32'd1;
            end
            if (i_cmd.emit_in || i_cmd.emit_held) begin
                r_pos <= r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_data <= i_data;
        end
        if (i_cmd.load) begin
            r_w <= init_w;
        end else if (i_cmd.step) begin
            r_w <= n_w;
        end else if (i_cmd.final_add) begin
            r_w <= n_fin;
        end
        if (i_cmd.emit_in) begin
            r_out_data <= i_data ^ ks_byte;
        end else if (i_cmd.emit_held) begin
            r_out_data <= r_data ^ ks_byte;
        end
    end

    assign o_status.pos_zero = (r_pos == 6'd0);
    assign o_data            = r_out_data;

endmodule

// ===== sv/cc20_ctrl.sv =====
`include "assert_macros.svh"

module cc20_ctrl #(
    parameter int ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  logic              i_s_restart,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  cc20_pkg::t_status i_status,
    output cc20_pkg::t_cmd    o_cmd
);

    localparam int RW = $clog2(ROUND_COUNT);
    localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

    cc20_pkg::t_state r_state, n_state;
    logic [RW-1:0]    r_round, n_round;
    logic [1:0]       r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;
    logic             need_block;

    assign out_free   = !r_out_valid || i_m_ready;
    assign accept     = i_s_valid && o_s_ready;
    assign need_block = i_s_restart || i_status.pos_zero;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cc20_pkg::ST_IDLE: begin
                if (accept && need_block) begin
                    n_state = cc20_pkg::ST_LOAD;
                end
            end
            cc20_pkg::ST_LOAD:  n_state = cc20_pkg::ST_ROUND;
            cc20_pkg::ST_ROUND: begin
                if (r_step == 2'd3 && r_round == LAST_ROUND) begin
                    n_state = cc20_pkg::ST_FINAL;
                end
            end
            cc20_pkg::ST_FINAL: n_state = cc20_pkg::ST_EMIT;
            cc20_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = cc20_pkg::ST_IDLE;
                end
            end
            default: n_state = cc20_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready       = 1'b0;
        o_cmd           = '0;
        o_cmd.step_idx  = r_step;
        o_cmd.diag      = r_round[0];
        n_round         = r_round;
        n_step          = r_step;
        case (r_state)
            cc20_pkg::ST_IDLE: begin
                o_s_ready     = out_free;
                o_cmd.capture = accept;
                o_cmd.emit_in = accept && !need_block;
            end
            cc20_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_round    = '0;
                n_step     = '0;
            end
            cc20_pkg::ST_ROUND: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_round = r_round + RW'(1);
                end
            end
            cc20_pkg::ST_FINAL: o_cmd.final_add = 1'b1;
            cc20_pkg::ST_EMIT:  o_cmd.emit_held = out_free;
            default: ;
        endcase
        n_out_valid = r_out_valid && !i_m_ready;
        if (o_cmd.emit_in || o_cmd.emit_held) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cc20_pkg::ST_IDLE;
            r_round     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    `ASSERT_NEVER(a_no_overwrite, (o_cmd.emit_in || o_cmd.emit_held) && r_out_valid && !i_m_ready, "result overwritten before it was taken")
    `ASSERT_CLK(a_final_after_round, (r_state == cc20_pkg::ST_FINAL) |-> ($past(r_state) == cc20_pkg::ST_ROUND), "final add without rounds")
    `ASSERT_CLK(a_emit_entry, (r_state == cc20_pkg::ST_EMIT) |-> ($past(r_state) == cc20_pkg::ST_FINAL || $past(r_state) == cc20_pkg::ST_EMIT), "emit outside block path")
    `ASSERT_CLK(a_load_after_capture, (r_state == cc20_pkg::ST_LOAD) |-> $past(o_cmd.capture), "block load without an accepted beat")

endmodule

// ===== sv/chacha20_stream_cipher.sv =====
// Channel        Direction  Payload
// s_axis         in         tdata: data_in[7:0]; tuser: restart_stream
// m_axis         out        tdata: data_out[7:0]
// cfg            in         index[2:0] selects the register, data[63:0]
//
// Within a block one beat is taken per cycle while the output is free; the result is registered.
// A beat at byte position 0 or with restart set holds the input through its own cycle,
// the load, 4 * ROUND_COUNT steps of the single quarter-round unit (one add, xor and
// rotate per cycle on four lanes), the final add and the emit.
// Reset is synchronous and active low; it clears the config registers, counter and position.
// Output stalls are absorbed by the output register; input is held off while it is full and not taken.
module chacha20_stream_cipher #(
    parameter int ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // data_in[7:0]
    input  logic                            s_axis_tuser,  // restart_stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // data_out[7:0]
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cc20_pkg::t_cmd    cmd;
    cc20_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    cc20_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .i_s_restart (s_axis_tuser),
        .o_s_ready   (s_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cc20_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_restart   (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (m_axis_tdata)
    );

endmodule
